// ===== src/ccce_pkg.sv =====
`default_nettype none

package ccce_pkg;

  // Fixed widths of the data path.
  localparam int DATA_W    = 32;
  localparam int SAT_W     = 72;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int SQRT_W    = 64;
  localparam int DIM_W     = 5;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  // Operation codes of an input transaction.
  typedef enum logic [2:0] {
    OP_WR_MATRIX = 3'd0,
    OP_WR_CENTER = 3'd1,
    OP_WR_POINT  = 3'd2,
    OP_REBUILD   = 3'd3,
    OP_MOVE      = 3'd4,
    OP_INTERSECT = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NEG_DISC = 2'd1,
    STAT_BAD_DIAG = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic [3:0]               index;
    logic [3:0]               column;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] t_low;
    logic signed [DATA_W-1:0] t_high;
    logic [1:0]               status;
    logic                     inside_res;
  } result_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    RB_READ,
    RB_DIFF,
    RB_MUL,
    RB_ACC,
    RB_ROW,
    RB_LMUL,
    RB_LACC,
    RB_FIN,
    MV_READ,
    MV_LOAD,
    MV_K,
    MV_LMUL,
    MV_LACC,
    MV_CREAD,
    MV_CLOAD,
    MV_CWR,
    IX_READ,
    IX_LOAD,
    IX_M2,
    IX_DISC,
    IX_SQRT,
    IX_D0S,
    IX_D0W,
    IX_D1S,
    IX_D1W,
    ST_DONE
  } state_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [DATA_W-1:0] res;
    if (x > 72'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (x < -72'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = x[DATA_W-1:0];
    end
    return res;
  endfunction

  // Saturating 64-bit signed add.
  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] sum;
    logic signed [63:0] res;
    sum = 65'(a) + 65'(b);
    if (sum[64] != sum[63]) begin
      res = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      res = sum[63:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/ccce_ram.sv =====
`default_nettype none

module ccce_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ccce_sqrt.sv =====
`default_nettype none

module ccce_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ccce_pkg::SQRT_W-1:0]     radicand,
  output logic                            busy,
  output logic                            done,
  output logic [ccce_pkg::SQRT_W/2-1:0]   root
);
  import ccce_pkg::*;

  logic [SQRT_W-1:0] v_q;
  logic [SQRT_W-1:0] r_q;
  logic [SQRT_W-1:0] bit_q;
  logic [SQRT_W-1:0] trial;

  assign trial = r_q + bit_q;
  assign root  = r_q[SQRT_W/2-1:0];

  // Control: one result bit per cycle, finished after the lowest bit pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_q[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Digit-by-digit square root step.
  always_ff @(posedge clk) begin
    if (start) begin
      v_q   <= radicand;
      r_q   <= '0;
      bit_q <= SQRT_W'(1) << (SQRT_W - 2);
    end else if (busy) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

`default_nettype wire

// ===== src/ccce_div.sv =====
`default_nettype none

module ccce_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ccce_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [ccce_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                            busy,
  output logic                            done,
  output logic [ccce_pkg::DIV_NUM_W-1:0]  quotient,
  output logic                            rem_nonzero
);
  import ccce_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [CW-1:0]        cnt_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  assign rem_sh      = {rem_q, num_q[DIV_NUM_W-1]};
  assign fits        = rem_sh >= {1'b0, den_q};
  assign quotient    = num_q;
  assign rem_nonzero = |rem_q;

  // Control: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt_q <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt_q <= '0;
      end else if (busy) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division; quotient bits shift in behind the dividend.
  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= dividend;
      rem_q <= '0;
      den_q <= divisor;
    end else if (busy) begin
      num_q <= {num_q[DIV_NUM_W-2:0], fits};
      rem_q <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/ellipsoid_coordinate_chord_engine_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_data  (item_t)
// out       output     out_valid/out_stall out_data (result_t)
// cfg       input      cfg_write           cfg_data (dimension)
//
// One transaction is worked at a time; the next is taken once the result sits in the
// output register. An intersect is dominated by its 32 square root steps and by two
// 64-step divides, one for each chord root.
// Synchronous reset; no clearing pass: the cached product reads zero until written.
// A stalled result holds in the output register while the next transaction is worked.
module ellipsoid_coordinate_chord_engine_unit #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ccce_pkg::item_t             in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ccce_pkg::result_t           out_data,
  input  logic                        cfg_write,
  input  logic [ccce_pkg::DIM_W-1:0]  cfg_data
);
  import ccce_pkg::*;

  localparam int IW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW     = $clog2(MAX_DIM + 1);
  localparam int MDEPTH = MAX_DIM * MAX_DIM;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam logic signed [DATA_W-1:0] LEVEL_RST = -(32'sd1 <<< FRAC_BITS);
  localparam logic signed [63:0]       LEV_INIT  = -(64'sd1 <<< (2 * FRAC_BITS));

  function automatic logic [MAW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return MAW'(r) * MAW'(MAX_DIM) + MAW'(c);
  endfunction

  // Floor-rounded quotient sign and saturation.
  function automatic logic signed [DATA_W-1:0] root_fix(input logic neg,
                                                        input logic [DIV_NUM_W-1:0] q,
                                                        input logic rnz);
    logic [DIV_NUM_W:0]       q2;
    logic signed [DATA_W-1:0] res;
    q2 = (DIV_NUM_W + 1)'(q) + (DIV_NUM_W + 1)'(rnz);
    if (!neg) begin
      res = (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[DATA_W-1:0];
    end else if (q2 > 65'h80000000) begin
      res = 32'sh80000000;
    end else begin
      res = DATA_W'(-q2);
    end
    return res;
  endfunction

  state_t                   state;
  state_t                   state_next;
  item_t                    item_q;
  logic [DIM_W-1:0]         dim_q;
  logic [NW-1:0]            n_used;
  logic signed [DATA_W-1:0] level_q;
  logic [MAX_DIM-1:0]       off_valid;
  logic                     off_vld_q;

  logic [NW-1:0]            row_q;
  logic [NW-1:0]            col_q;
  logic                     row_last;
  logic                     col_last;
  logic [IW-1:0]            d_idx;
  logic [IW-1:0]            c_idx;
  logic [IW-1:0]            row_idx;
  logic [IW-1:0]            col_idx;
  logic                     range_bad;
  logic [1:0]               status_q;
  logic signed [DATA_W-1:0] t0_q;
  logic signed [DATA_W-1:0] t1_q;

  logic signed [63:0]       acc_q;
  logic signed [63:0]       lev_q;
  logic signed [DATA_W-1:0] diff_q;
  logic signed [DATA_W-1:0] diffi_q;
  logic signed [DATA_W-1:0] amat_q;
  logic signed [DATA_W-1:0] hreg_q;
  logic signed [DATA_W-1:0] kreg_q;
  logic signed [DATA_W-1:0] creg_q;
  logic signed [63:0]       hh_q;
  logic [DATA_W-1:0]        s_q;
  logic                     neg_q;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [63:0]       prod_q;

  logic                     mat_we;
  logic [MAW-1:0]           mat_waddr;
  logic [MAW-1:0]           mat_raddr;
  logic [DATA_W-1:0]        mat_wdata;
  logic [DATA_W-1:0]        mat_rdata;
  logic                     ctr_we;
  logic                     pnt_we;
  logic [IW-1:0]            vec_raddr;
  logic [DATA_W-1:0]        vec_wdata;
  logic [DATA_W-1:0]        ctr_rdata;
  logic [DATA_W-1:0]        pnt_rdata;
  logic                     off_we;
  logic [IW-1:0]            off_waddr;
  logic [IW-1:0]            off_raddr;
  logic [DATA_W-1:0]        off_wdata;
  logic [DATA_W-1:0]        off_rdata;

  logic signed [DATA_W-1:0] mat_rd;
  logic signed [DATA_W-1:0] off_data;
  logic signed [DATA_W-1:0] diff_w;
  logic signed [DATA_W-1:0] coff_w;
  logic signed [DATA_W-1:0] pnt_new_w;
  logic signed [DATA_W-1:0] k_w;
  logic signed [DATA_W-1:0] cnew_w;
  logic signed [64:0]       disc_w;
  logic signed [34:0]       num_w;
  logic [33:0]              mag_w;

  logic                     sqrt_start;
  logic                     sqrt_busy;
  logic                     sqrt_done;
  logic [DATA_W-1:0]        sqrt_root;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [DIV_NUM_W-1:0]     div_quot;
  logic                     div_rnz;
  logic                     out_load;

  // Coordinates in use: zero acts as one, too large acts as the maximum.
  always_comb begin
    if (dim_q == '0) begin
      n_used = NW'(1);
    end else if (int'(dim_q) > MAX_DIM) begin
      n_used = NW'(MAX_DIM);
    end else begin
      n_used = NW'(dim_q);
    end
  end

  assign d_idx    = IW'(item_q.index);
  assign c_idx    = IW'(item_q.column);
  assign row_idx  = IW'(row_q);
  assign col_idx  = IW'(col_q);
  assign row_last = NW'(row_q + 1'b1) == n_used;
  assign col_last = NW'(col_q + 1'b1) == n_used;
  assign in_stall = state != ST_IDLE;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // Index checks for the operation being dispatched.
  always_comb begin
    unique case (item_q.operation)
      OP_WR_MATRIX:               range_bad = (int'(item_q.index) >= MAX_DIM) ||
                                              (int'(item_q.column) >= MAX_DIM);
      OP_WR_CENTER, OP_WR_POINT:  range_bad = int'(item_q.index) >= MAX_DIM;
      OP_MOVE, OP_INTERSECT:      range_bad = int'(item_q.index) >= int'(n_used);
      default:                    range_bad = 1'b0;
    endcase
  end

  // Arithmetic between the memories and the working registers.
  assign mat_rd    = $signed(mat_rdata);
  assign off_data  = off_vld_q ? $signed(off_rdata) : '0;
  assign diff_w    = sat32(SAT_W'($signed(pnt_rdata)) - SAT_W'($signed(ctr_rdata)));
  assign coff_w    = sat32(SAT_W'(acc_q >>> FRAC_BITS));
  assign pnt_new_w = sat32(SAT_W'($signed(pnt_rdata)) + SAT_W'(item_q.value));
  assign k_w       = sat32((SAT_W'(hreg_q) <<< 1) + SAT_W'(prod_q >>> FRAC_BITS));
  assign cnew_w    = sat32(SAT_W'(hreg_q) + SAT_W'(prod_q >>> FRAC_BITS));
  assign disc_w    = 65'(hh_q) - 65'(prod_q);
  assign num_w     = (state == IX_D0S) ? (-35'(hreg_q) - $signed({3'b000, s_q}))
                                       : (-35'(hreg_q) + $signed({3'b000, s_q}));
  assign mag_w     = num_w[34] ? 34'(-num_w) : 34'(num_w);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory ports, multiplier operands and unit starts.
  always_comb begin
    state_next = state;
    mat_we     = 1'b0;
    mat_waddr  = mat_addr(d_idx, c_idx);
    mat_wdata  = item_q.value;
    mat_raddr  = mat_addr(d_idx, d_idx);
    ctr_we     = 1'b0;
    pnt_we     = 1'b0;
    vec_raddr  = d_idx;
    vec_wdata  = item_q.value;
    off_we     = 1'b0;
    off_waddr  = row_idx;
    off_wdata  = cnew_w;
    off_raddr  = d_idx;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_DONE;
        if (!range_bad) begin
          unique case (item_q.operation)
            OP_WR_MATRIX: mat_we = 1'b1;
            OP_WR_CENTER: ctr_we = 1'b1;
            OP_WR_POINT:  pnt_we = 1'b1;
            OP_REBUILD:   state_next = RB_READ;
            OP_MOVE:      state_next = MV_READ;
            OP_INTERSECT: state_next = IX_READ;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      // Rebuild: each matrix term is read, differenced, multiplied and accumulated in turn.
      RB_READ: begin
        mat_raddr  = mat_addr(row_idx, col_idx);
        vec_raddr  = col_idx;
        state_next = RB_DIFF;
      end
      RB_DIFF: state_next = RB_MUL;
      RB_MUL: begin
        mul_a      = amat_q;
        mul_b      = diff_q;
        state_next = RB_ACC;
      end
      RB_ACC: state_next = col_last ? RB_ROW : RB_READ;
      RB_ROW: begin
        off_we     = 1'b1;
        off_wdata  = coff_w;
        state_next = RB_LMUL;
      end
      RB_LMUL: begin
        mul_a      = diffi_q;
        mul_b      = creg_q;
        state_next = RB_LACC;
      end
      RB_LACC: state_next = row_last ? RB_FIN : RB_READ;
      RB_FIN:  state_next = ST_DONE;
      // Move: point, level, then each cache entry in turn (read, load, write).
      MV_READ: state_next = MV_LOAD;
      MV_LOAD: begin
        pnt_we     = 1'b1;
        vec_wdata  = pnt_new_w;
        mul_a      = item_q.value;
        mul_b      = mat_rd;
        state_next = MV_K;
      end
      MV_K: state_next = MV_LMUL;
      MV_LMUL: begin
        mul_a      = item_q.value;
        mul_b      = kreg_q;
        state_next = MV_LACC;
      end
      MV_LACC: state_next = MV_CREAD;
      MV_CREAD: begin
        mat_raddr  = mat_addr(row_idx, d_idx);
        off_raddr  = row_idx;
        state_next = MV_CLOAD;
      end
      MV_CLOAD: begin
        mul_a      = item_q.value;
        mul_b      = mat_rd;
        state_next = MV_CWR;
      end
      MV_CWR: begin
        off_we     = 1'b1;
        state_next = row_last ? ST_DONE : MV_CREAD;
      end
      // Intersect: discriminant, square root, two divides.
      IX_READ: state_next = IX_LOAD;
      IX_LOAD: begin
        mul_a      = off_data;
        mul_b      = off_data;
        state_next = (mat_rd <= 0) ? ST_DONE : IX_M2;
      end
      IX_M2: begin
        mul_a      = amat_q;
        mul_b      = level_q;
        state_next = IX_DISC;
      end
      IX_DISC: begin
        if (disc_w[64]) begin
          state_next = ST_DONE;
        end else begin
          sqrt_start = 1'b1;
          state_next = IX_SQRT;
        end
      end
      IX_SQRT: state_next = sqrt_done ? IX_D0S : IX_SQRT;
      IX_D0S: begin
        div_start  = 1'b1;
        state_next = IX_D0W;
      end
      IX_D0W: state_next = div_done ? IX_D1S : IX_D0W;
      IX_D1S: begin
        div_start  = 1'b1;
        state_next = IX_D1W;
      end
      IX_D1W: state_next = div_done ? ST_DONE : IX_D1W;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: configuration, level, cache valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_q     <= DIM_RESET;
      level_q   <= LEVEL_RST;
      off_valid <= '0;
    end else begin
      if (cfg_write) begin
        dim_q <= cfg_data;
      end
      if (off_we) begin
        off_valid[off_waddr] <= 1'b1;
      end
      if (state == RB_FIN) begin
        level_q <= sat32(SAT_W'(lev_q >>> FRAC_BITS));
      end else if (state == MV_LACC) begin
        level_q <= sat32(SAT_W'(level_q) + SAT_W'(prod_q >>> FRAC_BITS));
      end
    end
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod_q    <= 64'(mul_a) * 64'(mul_b);
    off_vld_q <= off_valid[off_raddr];
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_q <= in_data;
    end
    unique case (state)
      ST_DISPATCH: begin
        status_q <= range_bad ? STAT_RANGE : STAT_OK;
        t0_q     <= '0;
        t1_q     <= '0;
        row_q    <= '0;
        col_q    <= '0;
        acc_q    <= '0;
        lev_q    <= LEV_INIT;
      end
      RB_DIFF: begin
        diff_q <= diff_w;
        amat_q <= mat_rd;
        if (col_q == row_q) begin
          diffi_q <= diff_w;
        end
      end
      RB_ACC: begin
        acc_q <= sadd64(acc_q, prod_q);
        col_q <= col_q + 1'b1;
      end
      RB_ROW: creg_q <= coff_w;
      RB_LACC: begin
        lev_q <= sadd64(lev_q, prod_q);
        row_q <= row_q + 1'b1;
        col_q <= '0;
        acc_q <= '0;
      end
      MV_LOAD: hreg_q <= off_data;
      MV_K:    kreg_q <= k_w;
      MV_CLOAD: hreg_q <= off_data;
      MV_CWR:  row_q <= row_q + 1'b1;
      IX_LOAD: begin
        amat_q <= mat_rd;
        hreg_q <= off_data;
        if (mat_rd <= 0) begin
          status_q <= STAT_BAD_DIAG;
        end
      end
      IX_M2: hh_q <= prod_q;
      IX_DISC: begin
        if (disc_w[64]) begin
          status_q <= STAT_NEG_DISC;
        end
      end
      IX_SQRT: begin
        if (sqrt_done) begin
          s_q <= sqrt_root;
        end
      end
      IX_D0S, IX_D1S: neg_q <= num_w[34];
      IX_D0W: begin
        if (div_done) begin
          t0_q <= root_fix(neg_q, div_quot, div_rnz);
        end
      end
      IX_D1W: begin
        if (div_done) begin
          t1_q <= root_fix(neg_q, div_quot, div_rnz);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.t_low      <= t0_q;
      out_data.t_high     <= t1_q;
      out_data.status     <= status_q;
      out_data.inside_res <= level_q <= 0;
    end
  end

  // State memories.
  ccce_ram #(.DEPTH(MDEPTH), .WIDTH(DATA_W)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  ccce_ram #(.DEPTH(MAX_DIM), .WIDTH(DATA_W)) u_ctr (
    .clk(clk), .we(ctr_we), .waddr(d_idx), .wdata(vec_wdata),
    .raddr(vec_raddr), .rdata(ctr_rdata)
  );

  ccce_ram #(.DEPTH(MAX_DIM), .WIDTH(DATA_W)) u_pnt (
    .clk(clk), .we(pnt_we), .waddr(d_idx), .wdata(vec_wdata),
    .raddr(vec_raddr), .rdata(pnt_rdata)
  );

  ccce_ram #(.DEPTH(MAX_DIM), .WIDTH(DATA_W)) u_off (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata)
  );

  // Iterative units for the chord roots.
  ccce_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(disc_w[63:0]),
    .busy(sqrt_busy), .done(sqrt_done), .root(sqrt_root)
  );

  ccce_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(DIV_NUM_W'(mag_w) << FRAC_BITS), .divisor(amat_q),
    .busy(div_busy), .done(div_done), .quotient(div_quot), .rem_nonzero(div_rnz)
  );

  // Cache valid bits are only ever set after reset.
  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((off_valid & $past(off_valid)) == $past(off_valid)))
    else $error("cache valid bit cleared outside reset");

  // The square root and the divider never work at the same time.
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sqrt_busy && div_busy))
    else $error("square root and divider overlap");

  // A result with an error status carries zero roots.
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STAT_OK) |->
      (out_data.t_low == '0 && out_data.t_high == '0))
    else $error("nonzero roots with error status");

  // Roots come out ordered.
  a_roots_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.t_low <= out_data.t_high))
    else $error("chord roots out of order");

endmodule

`default_nettype wire
